### sv/odo_pkg.sv
// Shared constants, widths and the arctangent table of the odometry pose integrator.
package odo_pkg;

  // Fraction bits of sine and cosine, also the CORDIC iteration count (10..24).
  localparam int TRIG_BITS = 16;

  // CORDIC datapath widths.
  localparam int CW     = TRIG_BITS + 3;          // x and y, signed
  localparam int ZW     = 34;                     // residual angle, 2^-32 turn
  localparam int ITER_W = $clog2(TRIG_BITS);      // iteration counter

  // Gain 0.60725293500888 in Q30, rounded to nearest at TRIG_BITS fraction bits.
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam logic signed [CW-1:0] CORDIC_X0 =
    CW'((GAIN_Q30 + (longint'(1) << (29 - TRIG_BITS))) >>> (30 - TRIG_BITS));

  // Rotation products and the shift that brings them to Q16.16.
  localparam int PW = 16 + CW;                    // one product
  localparam int AW = PW + 1;                     // sum of two products
  localparam int SH = TRIG_BITS + 12 - 16;        // positive over the whole range
  localparam int SW = (AW + 2 > 34) ? AW + 2 : 34;

  // Turn-rate divider: |left - right| * 256 over the wheel base.
  localparam int DIV_NW = 24;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = $clog2(DIV_NW);

  // atan(2^-i) in 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### sv/odo_cordic.sv
// Iterative CORDIC: sine and cosine of a 16-bit binary angle, one micro-rotation per cycle.
module odo_cordic import odo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [15:0]          heading,
  output logic                 done,
  output logic signed [CW-1:0] sin_val,
  output logic signed [CW-1:0] cos_val
);

  logic                 busy_r;
  logic                 done_r;
  logic [ITER_W-1:0]    iter_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic                 flip_r;

  logic                 flip;
  logic [31:0]          angle;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] atan_z;

  // Fold the second and third quadrants onto the first and fourth by a half turn.
  assign flip  = heading[15] ^ heading[14];
  assign angle = {heading[15] ^ flip, heading[14:0], 16'h0000};

  assign xs     = x_r >>> iter_r;
  assign ys     = y_r >>> iter_r;
  assign atan_z = $signed({2'b00, atan_turn(5'(iter_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && iter_r == ITER_W'(TRIG_BITS - 1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      iter_r <= '0;
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= ZW'($signed(angle));
      flip_r <= flip;
    end else if (busy_r) begin
      iter_r <= iter_r + 1'b1;
      if (!z_r[ZW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_z;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_z;
      end
    end
  end

  assign done    = done_r;
  assign cos_val = flip_r ? -x_r : x_r;
  assign sin_val = flip_r ? -y_r : y_r;

endmodule

### sv/odo_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module odo_div import odo_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;

  logic [DIV_DW:0]   rem_sh;
  logic              fits;
  logic [DIV_DW-1:0] rem_nxt;

  assign rem_sh  = {rem_r, num_r[DIV_NW-1]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_nxt = fits ? DIV_DW'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == DIV_CW'(DIV_NW - 1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      num_r <= num;
      quo_r <= '0;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      num_r <= {num_r[DIV_NW-2:0], 1'b0};
      quo_r <= {quo_r[DIV_NW-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### sv/odometry_pose_integrator_core.sv
// Top level: differential-drive pose integrator with shared CORDIC, multiplier and divider.
//
//  channel | ports                      | width | direction | content
//  --------+----------------------------+-------+-----------+------------------------------
//  in      | in_tvalid/tready/tdata/tuser | 144+1 | in        | one odometry status report
//  out     | out_tvalid/tready/tdata    | 176   | out       | pose, speeds, encoder totals
//  cfg     | cfg_valid/ready/data       | 16    | in        | wheel base, unsigned Q8.8
//
//  A valid report passes through S_TRIG, S_MAC, S_WAIT and S_UPD to S_DONE; the
//  24-step turn-rate divider finishes last, after the 16-step CORDIC and the
//  products through the one multiplier. The result is loaded and the sequencer
//  returns to S_IDLE in the same cycle, so the next report can then transfer.
//  A report flagged invalid goes straight to S_DONE and returns the current state.
//  in_tready is high only while the sequencer is idle; a result waiting on
//  out_tready does not hold back the next input transfer, but the next finished
//  report then waits in its final state, in_tready low, until the result frees.
//  rst_n is synchronous: pose, heading, totals and speeds clear, wheel base
//  returns to 1.0 m. cfg_ready is always high.
module odometry_pose_integrator_core import odo_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // report stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // delta_x[15:0], delta_y[31:16], delta_heading[47:32], left_pulses[79:48],
  // right_pulses[111:80], left_speed[127:112], right_speed[143:128]
  input  logic [143:0] in_tdata,
  // report_valid[0]
  input  logic [0:0]   in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // pose_x[31:0], pose_y[63:32], pose_heading[79:64], linear_speed[95:80],
  // turn_rate[111:96], left_total[143:112], right_total[175:144]
  output logic [175:0] out_tdata,
  // wheel base register
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRIG = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (SH - 1);

  // architectural state
  logic [15:0]        wheel_base_r;
  logic signed [31:0] pos_x_r;
  logic signed [31:0] pos_y_r;
  logic [15:0]        heading_r;
  logic [31:0]        left_tot_r;
  logic [31:0]        right_tot_r;
  logic [15:0]        lin_r;
  logic [15:0]        turn_r;

  // captured report
  logic signed [15:0] dx_r;
  logic signed [15:0] dy_r;
  logic [15:0]        dh_r;
  logic [31:0]        lp_r;
  logic [31:0]        rp_r;
  logic signed [15:0] ls_r;
  logic signed [15:0] rs_r;
  logic               neg_r;
  logic               zero_r;

  // sequencer and multiply-accumulate
  logic [2:0]           state_r;
  logic [2:0]           state_nxt;
  logic [2:0]           step_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_x_r;
  logic signed [AW-1:0] acc_y_r;

  // result register
  logic         out_valid_r;
  logic [175:0] out_data_r;

  logic                 in_xfer;
  logic                 start;
  logic signed [16:0]   diff_in;
  logic [16:0]          diff_abs;
  logic [DIV_NW-1:0]    div_num;
  logic [DIV_NW-1:0]    quo;
  logic                 div_done;
  logic                 trig_done;
  logic signed [CW-1:0] sin_val;
  logic signed [CW-1:0] cos_val;
  logic signed [15:0]   mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [SW-1:0] rnd_x;
  logic signed [SW-1:0] rnd_y;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [31:0]   sat_x;
  logic signed [31:0]   sat_y;
  logic [16:0]          lin_sum;
  logic [15:0]          turn_val;
  logic                 out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign start     = in_xfer && in_tuser[0];
  assign cfg_ready = 1'b1;

  // Divide the magnitude of the speed difference; the sign goes back on after.
  assign diff_in  = 17'($signed(in_tdata[127:112])) - 17'($signed(in_tdata[143:128]));
  assign diff_abs = diff_in[16] ? 17'(-diff_in) : 17'(diff_in);
  assign div_num  = {diff_abs[15:0], 8'h00};

  odo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .heading (heading_r),
    .done    (trig_done),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  odo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (div_num),
    .den   (wheel_base_r),
    .done  (div_done),
    .quo   (quo)
  );

  // Four products through one multiplier: dx*c, dy*s, dx*s, dy*c.
  always_comb begin
    case (step_r)
      3'd0:    begin mul_a = dx_r; mul_b = cos_val; end
      3'd1:    begin mul_a = dy_r; mul_b = sin_val; end
      3'd2:    begin mul_a = dx_r; mul_b = sin_val; end
      default: begin mul_a = dy_r; mul_b = cos_val; end
    endcase
  end

  // Round half up to Q16.16, add to the pose, clamp to 32 bits.
  assign rnd_x = (SW'(acc_x_r) + RND_HALF) >>> SH;
  assign rnd_y = (SW'(acc_y_r) + RND_HALF) >>> SH;
  assign sum_x = rnd_x + SW'(pos_x_r);
  assign sum_y = rnd_y + SW'(pos_y_r);

  always_comb begin
    if (sum_x[SW-1:31] == {(SW - 31){sum_x[31]}}) begin
      sat_x = sum_x[31:0];
    end else begin
      sat_x = sum_x[SW-1] ? {1'b1, 31'h0} : {1'b0, {31{1'b1}}};
    end
    if (sum_y[SW-1:31] == {(SW - 31){sum_y[31]}}) begin
      sat_y = sum_y[31:0];
    end else begin
      sat_y = sum_y[SW-1] ? {1'b1, 31'h0} : {1'b0, {31{1'b1}}};
    end
  end

  assign lin_sum = 17'(ls_r) + 17'(rs_r);

  // Clamp the signed quotient. A zero wheel base leaves an all-ones quotient,
  // which clamps to the full-scale rate of the difference's sign. Equal wheel
  // speeds give a zero rate whatever the wheel base.
  always_comb begin
    if (zero_r) begin
      turn_val = 16'h0000;
    end else if (!neg_r) begin
      turn_val = (quo[DIV_NW-1:15] != '0) ? 16'h7FFF : quo[15:0];
    end else if (quo[DIV_NW-1:16] != '0 || (quo[15] && quo[14:0] != '0)) begin
      turn_val = 16'h8000;
    end else begin
      turn_val = 16'(-quo[15:0]);
    end
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = in_tuser[0] ? S_TRIG : S_DONE;
        end
      end
      S_TRIG: begin
        if (trig_done) begin
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        if (step_r == 3'd4) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      wheel_base_r <= 16'd256;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      heading_r    <= '0;
      left_tot_r   <= '0;
      right_tot_r  <= '0;
      lin_r        <= '0;
      turn_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        wheel_base_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_UPD) begin
        pos_x_r     <= sat_x;
        pos_y_r     <= sat_y;
        heading_r   <= heading_r + dh_r;
        left_tot_r  <= left_tot_r + lp_r;
        right_tot_r <= right_tot_r + rp_r;
        lin_r       <= lin_sum[16:1];
        turn_r      <= turn_val;
      end
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      dx_r   <= $signed(in_tdata[15:0]);
      dy_r   <= $signed(in_tdata[31:16]);
      dh_r   <= in_tdata[47:32];
      lp_r   <= in_tdata[79:48];
      rp_r   <= in_tdata[111:80];
      ls_r   <= $signed(in_tdata[127:112]);
      rs_r   <= $signed(in_tdata[143:128]);
      neg_r  <= diff_in[16];
      zero_r <= (diff_in == 17'sd0);
    end
    if (state_r == S_TRIG) begin
      step_r <= '0;
    end else if (state_r == S_MAC) begin
      step_r <= step_r + 1'b1;
      prod_r <= mul_a * mul_b;
      case (step_r)
        3'd1:    acc_x_r <= AW'(prod_r);
        3'd2:    acc_x_r <= acc_x_r - AW'(prod_r);
        3'd3:    acc_y_r <= AW'(prod_r);
        3'd4:    acc_y_r <= acc_y_r + AW'(prod_r);
        default: acc_x_r <= acc_x_r;
      endcase
    end
    if (out_load) begin
      out_data_r <= {right_tot_r, left_tot_r, turn_r, lin_r, heading_r, pos_y_r, pos_x_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### sv/odo_chk.sv
// Port-level checker for the odometry pose integrator, bound to the top level.
module odo_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [0:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [175:0] out_tdata
);

  // Drop ready right after any transfer: one report at a time.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready stayed high after an input transfer");

  // A valid report keeps the sequencer busy well past its transfer.
  a_valid_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> ##2 !in_tready)
    else $error("valid report finished too early");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // No result straight out of reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind odometry_pose_integrator_core odo_chk u_odo_chk (.*);

### sim/odometry_pose_integrator_core_tb.sv
// Self-checking testbench for the odometry pose integrator core.
`timescale 1ns / 100ps

module odometry_pose_integrator_core_tb;

  // Clamped CORDIC iteration count and the shift from rotated products to Q16.16
  localparam int     TRIG_N     = (odo_pkg::TRIG_BITS < 1)  ? 1 :
                                  (odo_pkg::TRIG_BITS > 24) ? 24 : odo_pkg::TRIG_BITS;
  localparam int     ROUND_SH   = TRIG_N + 12 - 16;
  localparam longint GAIN_Q30   = 64'sd652032874;
  localparam longint POSE_MAX   = 64'sd2147483647;
  localparam longint POSE_MIN   = -64'sd2147483648;
  localparam longint TURN_MAX   = 64'sd32767;
  localparam longint TURN_MIN   = -64'sd32768;
  localparam int     DRAIN_WAIT = 40;

  // One status report, laid out so that {in_tuser, in_tdata} maps onto it directly
  typedef struct packed {
    logic               valid;
    logic signed [15:0] rs;
    logic signed [15:0] ls;
    logic        [31:0] rp;
    logic        [31:0] lp;
    logic signed [15:0] dh;
    logic signed [15:0] dy;
    logic signed [15:0] dx;
  } report_t;

  // One pose result, laid out to match out_tdata
  typedef struct packed {
    logic        [31:0] rt;
    logic        [31:0] lt;
    logic signed [15:0] turn;
    logic signed [15:0] lin;
    logic        [15:0] hd;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } pose_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  // delta_x[15:0], delta_y[31:16], delta_heading[47:32], left_pulses[79:48],
  // right_pulses[111:80], left_speed[127:112], right_speed[143:128]
  logic [143:0] in_tdata   = '0;
  // report_valid[0]
  logic [0:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // pose_x[31:0], pose_y[63:32], pose_heading[79:64], linear_speed[95:80],
  // turn_rate[111:96], left_total[143:112], right_total[175:144]
  logic [175:0] out_tdata;
  logic         cfg_valid  = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data   = '0;

  // Stimulus queues and the store of predicted poses
  report_t     report_q[$];
  logic [15:0] wheel_base_q[$];
  pose_t       pose_q[$];
  report_t     next_report;

  // Idling controls, changed per phase
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned in_gap        = 0;
  int unsigned out_stall     = 0;
  bit          failed        = 1'b0;

  // Predictor state
  logic signed [31:0] pos_x       = '0;
  logic signed [31:0] pos_y       = '0;
  logic        [15:0] heading_acc = '0;
  logic        [31:0] left_sum    = '0;
  logic        [31:0] right_sum   = '0;
  logic signed [15:0] lin_speed   = '0;
  logic signed [15:0] turn_speed  = '0;
  logic        [15:0] model_wheel_base = 16'd256;

  // atan(2^-i) in 2^-32 turn
  longint atan_lut [0:23] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
    64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
  };

  odometry_pose_integrator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] clamp_pose(input longint v);
    if (v > POSE_MAX) return POSE_MAX[31:0];
    if (v < POSE_MIN) return POSE_MIN[31:0];
    return v[31:0];
  endfunction

  // Sine and cosine of a heading, Q(TRIG_N). Fold the second and third quadrant
  // by a half turn, run the rotations, then negate to undo the fold.
  function automatic void cordic_sin_cos(input logic [15:0] hd,
                                         output longint sn, output longint cs);
    logic [31:0] ang;
    logic        flip;
    longint      x, y, z, xs, ys;
    ang  = {hd, 16'h0000};
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang ^ 32'h8000_0000;
    z = longint'($signed(ang));
    x = (GAIN_Q30 + (longint'(1) << (29 - TRIG_N))) >>> (30 - TRIG_N);
    y = 0;
    for (int i = 0; i < TRIG_N; i++) begin
      // arithmetic shifts on longint floor toward minus infinity
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_lut[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_lut[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // Apply one report to the predicted state and return the pose it shows
  function automatic pose_t integrate_report(input report_t r);
    longint sn, cs, wx, wy, diff, q;
    pose_t  p;
    if (r.valid) begin
      // rotate by the heading held before this report
      cordic_sin_cos(heading_acc, sn, cs);
      wx = longint'($signed(r.dx)) * cs - longint'($signed(r.dy)) * sn;
      wy = longint'($signed(r.dx)) * sn + longint'($signed(r.dy)) * cs;
      wx = (wx + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
      wy = (wy + (longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
      pos_x       = clamp_pose(longint'(pos_x) + wx);
      pos_y       = clamp_pose(longint'(pos_y) + wy);
      heading_acc = heading_acc + r.dh;
      left_sum    = left_sum + r.lp;
      right_sum   = right_sum + r.rp;
      q           = (longint'($signed(r.ls)) + longint'($signed(r.rs))) >>> 1;
      lin_speed   = q[15:0];
      diff        = longint'($signed(r.ls)) - longint'($signed(r.rs));
      if (model_wheel_base == 16'd0) begin
        // zero wheel base: pin to the rail matching the sign of the difference
        q = (diff > 0) ? TURN_MAX : ((diff < 0) ? TURN_MIN : 0);
      end else begin
        // SystemVerilog division truncates toward zero
        q = (diff * 256) / longint'(model_wheel_base);
        if (q > TURN_MAX) q = TURN_MAX;
        if (q < TURN_MIN) q = TURN_MIN;
      end
      turn_speed = q[15:0];
    end
    p.px   = pos_x;
    p.py   = pos_y;
    p.hd   = heading_acc;
    p.lin  = lin_speed;
    p.turn = turn_speed;
    p.lt   = left_sum;
    p.rt   = right_sum;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers and checker
  // ---------------------------------------------------------------------------

  // Report driver: hold the current transfer until accepted, then insert an
  // optional gap before presenting the next queued report.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (report_q.size() != 0) begin
        next_report = report_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_report[143:0];
        in_tuser  <= next_report[144];
        if ($urandom_range(0, 99) < in_idle_pct) in_gap <= $urandom_range(1, 13);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else if (out_stall != 0) begin
      out_tready <= 1'b0;
      out_stall  <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < out_stall_pct) out_stall <= $urandom_range(1, 13);
    end
  end

  // Wheel base writer: one transfer per queued value
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_data  <= '0;
    end else if (!cfg_valid || cfg_ready) begin
      if (wheel_base_q.size() != 0) begin
        cfg_valid <= 1'b1;
        cfg_data  <= wheel_base_q.pop_front();
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %h, got %h", name, expv, actv);
      failed = 1'b1;
    end
  endtask

  // Track register writes, predict on every accepted report and check every
  // accepted result against the oldest prediction. Pop before push so that a
  // result and a new report in the same cycle stay in order.
  always @(posedge clk) begin
    pose_t expv, got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) model_wheel_base = cfg_data;
      if (out_tvalid && out_tready) begin
        got = pose_t'(out_tdata);
        if (pose_q.size() == 0) begin
          $error("result transfer with no prediction pending: %h", out_tdata);
          failed = 1'b1;
        end else begin
          expv = pose_q.pop_front();
          compare_field("pose_x",       expv.px,          got.px);
          compare_field("pose_y",       expv.py,          got.py);
          compare_field("pose_heading", {16'h0, expv.hd}, {16'h0, got.hd});
          compare_field("linear_speed", {16'h0, expv.lin}, {16'h0, got.lin});
          compare_field("turn_rate",    {16'h0, expv.turn}, {16'h0, got.turn});
          compare_field("left_total",   expv.lt,          got.lt);
          compare_field("right_total",  expv.rt,          got.rt);
        end
      end
      if (in_tvalid && in_tready)
        pose_q.push_back(integrate_report(report_t'({in_tuser, in_tdata})));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic report_t make_report(input logic v, input logic [15:0] dx, dy, dh,
                                          input logic [31:0] lp, rp,
                                          input logic [15:0] ls, rs);
    report_t r;
    r.valid = v;
    r.dx    = dx;
    r.dy    = dy;
    r.dh    = dh;
    r.lp    = lp;
    r.rp    = rp;
    r.ls    = ls;
    r.rs    = rs;
    return r;
  endfunction

  // Field value biased toward the rails, zero and small magnitudes
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic report_t random_report();
    return make_report($urandom_range(0, 6) != 0, pick16(), pick16(), pick16(),
                       pick32(), pick32(), pick16(), pick16());
  endfunction

  // Straight drive at full stride with the heading held
  function automatic report_t drive_report(input bit ahead);
    logic [15:0] d;
    d = ahead ? 16'h7FFF - 16'($urandom_range(0, 7)) : 16'h8000 + 16'($urandom_range(0, 7));
    return make_report(1'b1, d, d, 16'h0000, pick32(), pick32(), pick16(), pick16());
  endfunction

  // Block until every report is in and every result is out, then let it settle.
  // Sample on the falling edge, where the drivers' updates have all landed.
  task automatic wait_drained();
    while (report_q.size() != 0 || in_tvalid || pose_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the wheel base while idle and pick the idling mix for the next phase
  task automatic set_wheel_base(input logic [15:0] v);
    wait_drained();
    wheel_base_q.push_back(v);
    @(posedge clk);
    while (wheel_base_q.size() != 0 || cfg_valid) @(negedge clk);
    in_idle_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
  endtask

  task automatic send_random(input int n);
    repeat (n) report_q.push_back(random_report());
  endtask

  initial begin
    logic [15:0] wb;
    in_idle_pct   = 20;
    out_stall_pct = 20;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed reports at the reset wheel base
    report_q.push_back(make_report(1'b0, 16'h1234, 16'h5678, 16'h4000,
                                   32'h1, 32'h2, 16'h0100, 16'h0200));
    report_q.push_back(make_report(1'b1, 16'h7FFF, 16'h0000, 16'h0000,
                                   32'hFFFF_FFFF, 32'h1, 16'h7FFF, 16'h8000));
    report_q.push_back(make_report(1'b1, 16'h8000, 16'h7FFF, 16'h4000,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF));
    // heading now on the quadrant boundaries in turn: quarter, half, three quarters
    report_q.push_back(make_report(1'b1, 16'h0000, 16'h8000, 16'h4000,
                                   32'h0, 32'hFFFF_FFFF, 16'h0001, 16'hFFFF));
    report_q.push_back(make_report(1'b1, 16'h7FFF, 16'h7FFF, 16'h4000,
                                   32'h8000_0000, 32'h8000_0000, 16'h0000, 16'h0000));
    report_q.push_back(make_report(1'b1, 16'h8000, 16'h8000, 16'h4000,
                                   32'h7FFF_FFFF, 32'h0, 16'h1234, 16'hEDCC));
    // heading wraps back to zero, then an eighth turn
    report_q.push_back(make_report(1'b1, 16'h0001, 16'hFFFF, 16'h2000,
                                   32'h0, 32'h0, 16'h0000, 16'h0001));
    report_q.push_back(make_report(1'b1, 16'h7FFF, 16'h0000, 16'h7FFF,
                                   32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'hAAAA));
    report_q.push_back(make_report(1'b1, 16'h0000, 16'h7FFF, 16'h8000,
                                   32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555));
    report_q.push_back(make_report(1'b1, 16'h1000, 16'hF000, 16'h0001,
                                   32'h0, 32'h0, 16'h8000, 16'h8000));
    // odd negative sum checks the floor of the mean
    report_q.push_back(make_report(1'b1, 16'hFFFF, 16'h0001, 16'hFFFF,
                                   32'h0, 32'h0, 16'hFFFD, 16'h0000));
    // invalid report keeps pose, totals and the last speeds
    report_q.push_back(make_report(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    report_q.push_back(make_report(1'b1, 16'h0000, 16'h0000, 16'h0000,
                                   32'h0, 32'h0, 16'h7FFF, 16'h7FFF));
    report_q.push_back(make_report(1'b1, 16'h0000, 16'h0000, 16'hC000,
                                   32'h0, 32'h0, 16'h0001, 16'h0000));

    // Zero wheel base: equal, higher and lower left speed
    set_wheel_base(16'd0);
    report_q.push_back(make_report(1'b1, 16'h0100, 16'h0100, 16'h0100,
                                   32'h1, 32'h1, 16'h0300, 16'h0300));
    report_q.push_back(make_report(1'b1, 16'h0100, 16'h0100, 16'h0100,
                                   32'h1, 32'h1, 16'h0001, 16'h0000));
    report_q.push_back(make_report(1'b1, 16'h0100, 16'h0100, 16'h0100,
                                   32'h1, 32'h1, 16'h8000, 16'h8001));
    send_random(120);

    // Smallest nonzero and largest wheel base
    set_wheel_base(16'd1);
    send_random(180);
    set_wheel_base(16'hFFFF);
    send_random(180);

    // Random wheel bases, mostly in the range a real robot would use
    repeat (4) begin
      wb = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 1024))
                                       : 16'($urandom_range(1, 65535));
      set_wheel_base(wb);
      send_random(180);
    end

    // Last part, no idling: straighten the heading, then drive out at full
    // stride and back again, back to back
    set_wheel_base(16'd256);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    report_q.push_back(make_report(1'b1, 16'h0000, 16'h0000, 16'(-heading_acc),
                                   32'h0, 32'h0, 16'h0000, 16'h0000));
    wait_drained();
    repeat (50) report_q.push_back(drive_report(1'b1));
    repeat (70) report_q.push_back(drive_report(1'b0));

    wait_drained();
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd2_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule

### odometry_pose_integrator_core.f
sv/odo_pkg.sv
sv/odo_cordic.sv
sv/odo_div.sv
sv/odometry_pose_integrator_core.sv
sv/odo_chk.sv
sim/odometry_pose_integrator_core_tb.sv
